@@ hdl/lkb_pkg.sv @@
`timescale 1ns / 1ps

package lkb_pkg;

  localparam int KEYFRAME_DEPTH_DEF = 256;
  localparam int FRACTION_BITS_DEF  = 8;

  localparam logic [7:0] MIN_FRAMES_RST = 8'd1;
  localparam logic [7:0] CAP_VALUE      = 8'd254;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_RENDER = 2'd2,
    REQ_NOP    = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [8:0]  frame_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [17:0] position_q8;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [8:0] stored_count;
    logic       status;
  } out_rsp_t;

endpackage

@@ hdl/lkb_ram.sv @@
`timescale 1ns / 1ps

module lkb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/led_keyframe_color_blender.sv @@
`timescale 1ns / 1ps

// Keyframe color blender. A transaction is taken when start is high and busy is
// low; exactly one result follows as a one-cycle out_valid strobe that cannot
// be held off. All keyframe traffic goes through one table with one write port
// and a registered read port, so the cost is set by table accesses: an accepted
// transaction first adds any black entries that growth needs, then a write
// stores its entry, a render does two reads, then one blend multiply-add per
// channel, and a delete moves the k entries above the deleted index down, one read
// and one write at a time. A write or delete with an index beyond the table is
// rejected at once: busy stays low and the strobe follows in the next cycle.
// min_frames may be rewritten only while busy is low.
module led_keyframe_color_blender
  import lkb_pkg::*;
#(
  parameter int KEYFRAME_DEPTH = KEYFRAME_DEPTH_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  output logic     out_valid,
  output out_rsp_t out_rsp,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int AW = $clog2(KEYFRAME_DEPTH);
  localparam int CW = $clog2(KEYFRAME_DEPTH + 1);
  localparam int IW = 18 - FRACTION_BITS;
  localparam int MW = ((IW > CW) ? IW : CW) + 1;
  localparam int PW = FRACTION_BITS + 10;
  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_GROW, S_OP, S_DEL_RD, S_DEL_WR, S_RD_CUR, S_RD_NXT, S_RD_WAIT, S_BLEND
  } state_t;

  state_t                 state_r;
  logic [CW-1:0]          count_r;
  logic [7:0]             min_frames_r;
  logic                   e0_valid_r;
  logic                   out_valid_r;
  in_item_t               item_r;
  logic [AW-1:0]          grow_top_r;
  logic [AW-1:0]          ptr_r;
  logic [AW-1:0]          cur_r;
  logic [AW-1:0]          nxt_r;
  logic [FRACTION_BITS:0] fade_r;
  logic [23:0]            cur_col_r;
  logic [23:0]            nxt_col_r;
  logic [1:0]             ch_r;
  logic [7:0]             res_red_r;
  logic [7:0]             res_green_r;
  logic [7:0]             res_blue_r;
  logic                   status_r;
  logic                   rd_blank_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [23:0]            ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [23:0]            ram_q;
  logic [23:0]            rd_data;

  logic                   idx_beyond;
  logic [AW-1:0]          mf_top;
  logic [AW-1:0]          idx_a;
  logic [AW-1:0]          grow_top;
  logic                   grow_more;
  logic                   del_more;

  logic [CW-1:0]          total;
  logic [IW-1:0]          pos_int;
  logic                   pos_beyond;
  logic [AW-1:0]          cur_sel;

  logic [7:0]             blend_c;
  logic [7:0]             blend_n;
  logic [PW-1:0]          blend_sum;
  logic [9:0]             blend_v;
  logic [7:0]             blend_out;

  // ---------------------------------------------------------------- accept
  always_comb begin
    idx_beyond = (in_item.req_type == REQ_WRITE || in_item.req_type == REQ_DELETE) &&
                 (32'(in_item.frame_index) >= 32'(KEYFRAME_DEPTH));
    mf_top = (32'(min_frames_r) >= 32'(KEYFRAME_DEPTH - 1)) ? AW'(KEYFRAME_DEPTH - 1)
                                                            : AW'(min_frames_r);
    idx_a = AW'(in_item.frame_index);
    grow_top = mf_top;
    if ((in_item.req_type == REQ_WRITE || in_item.req_type == REQ_DELETE) &&
        (idx_a > mf_top)) begin
      grow_top = idx_a;
    end
  end

  assign grow_more = (count_r <= CW'(grow_top_r));
  assign del_more  = ((CW + 1)'(ptr_r) + 1'b1) < (CW + 1)'(count_r);

  // ---------------------------------------------------------- render setup
  always_comb begin
    total      = (count_r > CW'(2)) ? (count_r - 1'b1) : CW'(1);
    pos_int    = item_r.position_q8[17:FRACTION_BITS];
    pos_beyond = MW'(pos_int) > (MW'(total) - 1'b1);
    cur_sel    = pos_beyond ? AW'(total - 1'b1) : AW'(pos_int);
  end

  // entry 0 reads black until it is first written
  assign rd_data = rd_blank_r ? 24'd0 : ram_q;

  // ------------------------------------------------------------ blend unit
  always_comb begin
    case (ch_r)
      2'd0: begin
        blend_c = cur_col_r[23:16];
        blend_n = nxt_col_r[23:16];
      end
      2'd1: begin
        blend_c = cur_col_r[15:8];
        blend_n = nxt_col_r[15:8];
      end
      default: begin
        blend_c = cur_col_r[7:0];
        blend_n = nxt_col_r[7:0];
      end
    endcase
    blend_sum = PW'(blend_c) * PW'(ONE - fade_r) + PW'(blend_n) * PW'(fade_r);
    blend_v   = blend_sum[FRACTION_BITS +: 10];
    blend_out = ((blend_v > 10'(CAP_VALUE)) ? CAP_VALUE : blend_v[7:0]) + 8'd1;
  end

  // -------------------------------------------------------- table controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(count_r);
    ram_wdata = 24'd0;
    ram_raddr = ptr_r + 1'b1;
    case (state_r)
      S_GROW: begin
        ram_we = grow_more;
      end
      S_OP: begin
        if (item_r.req_type == REQ_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(item_r.frame_index);
          ram_wdata = {item_r.red, item_r.green, item_r.blue};
        end
      end
      S_DEL_RD: begin
        if (!del_more && count_r == CW'(1)) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = rd_data;
      end
      S_RD_CUR: begin
        ram_raddr = cur_r;
      end
      S_RD_NXT: begin
        ram_raddr = nxt_r;
      end
      default: begin
      end
    endcase
  end

  lkb_ram #(
    .WIDTH (24),
    .DEPTH (KEYFRAME_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    rd_blank_r <= (ram_raddr == '0) && !e0_valid_r;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= CW'(1);
      min_frames_r <= MIN_FRAMES_RST;
      e0_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        min_frames_r <= cfg_wdata;
      end
      if (ram_we && ram_waddr == '0) begin
        e0_valid_r <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r      <= in_item;
            res_red_r   <= 8'd0;
            res_green_r <= 8'd0;
            res_blue_r  <= 8'd0;
            status_r    <= idx_beyond;
            grow_top_r  <= grow_top;
            if (idx_beyond) begin
              out_valid_r <= 1'b1;
            end else begin
              state_r <= S_GROW;
            end
          end
        end
        S_GROW: begin
          if (grow_more) begin
            count_r <= count_r + 1'b1;
          end else begin
            state_r <= S_OP;
          end
        end
        S_OP: begin
          case (item_r.req_type)
            REQ_DELETE: begin
              ptr_r   <= AW'(item_r.frame_index);
              state_r <= S_DEL_RD;
            end
            REQ_RENDER: begin
              cur_r   <= cur_sel;
              nxt_r   <= ((MW'(cur_sel) + 1'b1) == MW'(total)) ? '0 : (cur_sel + 1'b1);
              fade_r  <= pos_beyond ? ONE : {1'b0, item_r.position_q8[FRACTION_BITS-1:0]};
              state_r <= S_RD_CUR;
            end
            default: begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_DEL_RD: begin
          if (del_more) begin
            state_r <= S_DEL_WR;
          end else begin
            // deleting the only entry leaves one black entry
            if (count_r != CW'(1)) begin
              count_r <= count_r - 1'b1;
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_DEL_WR: begin
          ptr_r   <= ptr_r + 1'b1;
          state_r <= S_DEL_RD;
        end
        S_RD_CUR: begin
          state_r <= S_RD_NXT;
        end
        S_RD_NXT: begin
          cur_col_r <= rd_data;
          state_r   <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          nxt_col_r <= rd_data;
          ch_r      <= 2'd0;
          state_r   <= S_BLEND;
        end
        S_BLEND: begin
          case (ch_r)
            2'd0:    res_red_r   <= blend_out;
            2'd1:    res_green_r <= blend_out;
            default: res_blue_r  <= blend_out;
          endcase
          if (ch_r == 2'd2) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            ch_r <= ch_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    out_rsp.out_red      = res_red_r;
    out_rsp.out_green    = res_green_r;
    out_rsp.out_blue     = res_blue_r;
    out_rsp.stored_count = 9'(count_r);
    out_rsp.status       = status_r;
  end

`ifndef SYNTHESIS
  a_done_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result strobe");

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CW'(KEYFRAME_DEPTH)))
    else $error("entry count out of range");

  a_reject_black : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status) |->
      (out_rsp.out_red == 8'd0 && out_rsp.out_green == 8'd0 && out_rsp.out_blue == 8'd0))
    else $error("rejected transaction carries a color");
`endif

endmodule
